// ===== rtl/csc_pkg.sv =====
// shared constants, types and the arctangent table for the cordic sine/cosine pipeline
`default_nettype none
package csc_pkg;

  localparam int unsigned ITERATIONS = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SHIFT_W    = 5;

  localparam logic [DATA_W-1:0] ANG_45    = 32'h4000_0000;
  localparam logic [DATA_W-1:0] VAL_45    = 32'h5A82_0000;
  localparam logic [DATA_W-1:0] COS_ZERO  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] GAIN_INIT = 32'h4DBA_76D4;

  // one item in flight between stages
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] phi;
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] c;
  } stage_t;

  // atan(2^-i) in the angle scale, rounded to nearest
  function automatic logic [DATA_W-1:0] atan_entry(input logic [SHIFT_W-1:0] idx);
    logic [DATA_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h4000_0000;
      5'd1:    v = 32'h25C8_0A3B;
      5'd2:    v = 32'h13F6_70B7;
      5'd3:    v = 32'h0A22_23A8;
      5'd4:    v = 32'h0516_1A86;
      5'd5:    v = 32'h028B_AFC3;
      5'd6:    v = 32'h0145_EC3D;
      5'd7:    v = 32'h00A2_F8AA;
      5'd8:    v = 32'h0051_7CA7;
      5'd9:    v = 32'h0028_BE5D;
      5'd10:   v = 32'h0014_5F30;
      5'd11:   v = 32'h000A_2F98;
      5'd12:   v = 32'h0005_17CC;
      5'd13:   v = 32'h0002_8BE6;
      5'd14:   v = 32'h0001_45F3;
      5'd15:   v = 32'h0000_A2FA;
      5'd16:   v = 32'h0000_517D;
      5'd17:   v = 32'h0000_28BE;
      5'd18:   v = 32'h0000_145F;
      5'd19:   v = 32'h0000_0A30;
      5'd20:   v = 32'h0000_0518;
      5'd21:   v = 32'h0000_028C;
      5'd22:   v = 32'h0000_0146;
      5'd23:   v = 32'h0000_00A3;
      5'd24:   v = 32'h0000_0051;
      5'd25:   v = 32'h0000_0029;
      5'd26:   v = 32'h0000_0014;
      5'd27:   v = 32'h0000_000A;
      5'd28:   v = 32'h0000_0005;
      5'd29:   v = 32'h0000_0003;
      5'd30:   v = 32'h0000_0001;
      default: v = 32'h0000_0001;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/csc_regs.sv =====
// apb register file holding the start gain
`default_nettype none
module csc_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [1:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [csc_pkg::DATA_W-1:0] start_gain
);
  import csc_pkg::*;

  logic wr_en;

  // single register, every word-aligned address decodes to it
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = start_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_gain <= GAIN_INIT;
    end else if (wr_en) begin
      start_gain <= pwdata;
    end
  end

  logic unused_addr;
  assign unused_addr = ^paddr;

endmodule
`default_nettype wire

// ===== rtl/csc_front.sv =====
// input register: loads the vector and folds the two special angles
`default_nettype none
module csc_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [csc_pkg::DATA_W-1:0] angle,
  input  wire logic [csc_pkg::DATA_W-1:0] start_gain,
  output csc_pkg::stage_t                 stage_out
);
  import csc_pkg::*;

  stage_t stage_next;

  // special angles load the answer with phi equal to target so no stage rotates
  always_comb begin
    stage_next.valid  = start;
    stage_next.phi    = '0;
    if (angle == ANG_45) begin
      stage_next.target = '0;
      stage_next.s      = VAL_45;
      stage_next.c      = VAL_45;
    end else if (angle == '0) begin
      stage_next.target = '0;
      stage_next.s      = '0;
      stage_next.c      = COS_ZERO;
    end else begin
      stage_next.target = angle;
      stage_next.s      = '0;
      stage_next.c      = start_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_out.target <= stage_next.target;
    stage_out.phi    <= stage_next.phi;
    stage_out.s      <= stage_next.s;
    stage_out.c      <= stage_next.c;
  end

endmodule
`default_nettype wire

// ===== rtl/csc_stage.sv =====
// one registered cordic micro-rotation
`default_nettype none
module csc_stage (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [csc_pkg::SHIFT_W-1:0] idx,
  input  csc_pkg::stage_t                  stage_in,
  output csc_pkg::stage_t                  stage_out
);
  import csc_pkg::*;

  stage_t            stage_next;
  logic [DATA_W-1:0] s_sh;
  logic [DATA_W-1:0] c_sh;
  logic [DATA_W-1:0] atan_v;
  logic              fwd;
  logic              back;

  // idx is tied to a constant per instance, so the shifts are wiring
  assign s_sh   = stage_in.s >> idx;
  assign c_sh   = stage_in.c >> idx;
  assign atan_v = atan_entry(idx);
  assign fwd    = stage_in.phi < stage_in.target;
  assign back   = stage_in.phi > stage_in.target;

  always_comb begin
    stage_next = stage_in;
    if (fwd) begin
      stage_next.c   = stage_in.c - s_sh;
      stage_next.s   = stage_in.s + c_sh;
      stage_next.phi = stage_in.phi + atan_v;
    end else if (back) begin
      stage_next.c   = stage_in.c + s_sh;
      stage_next.s   = stage_in.s - c_sh;
      stage_next.phi = stage_in.phi - atan_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_out.target <= stage_next.target;
    stage_out.phi    <= stage_next.phi;
    stage_out.s      <= stage_next.s;
    stage_out.c      <= stage_next.c;
  end

endmodule
`default_nettype wire

// ===== rtl/cordic_sine_cosine.sv =====
// top level: apb gain register, input register and a chain of cordic stages
//
//  channel   signals                       direction  notes
//  request   start, busy, angle            in/out     taken when start & !busy (busy is out)
//  result    done, sine, cosine            out        valid for one cycle on done
//  config    psel..pwdata, prdata, pready  in/out     gain at address 0
//
// the chain is one input register plus one register
// per micro-rotation, each stage a compare and three 32-bit add/subtracts.
// a new request is taken every cycle; busy is tied low.
// rst clears the valid bits along the chain and restores the gain register.
// the receiver cannot stall, so results leave on done with no back-pressure.
`default_nettype none
module cordic_sine_cosine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [csc_pkg::DATA_W-1:0] angle,
  output logic                            done,
  output logic      [csc_pkg::DATA_W-1:0] sine,
  output logic      [csc_pkg::DATA_W-1:0] cosine,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [1:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import csc_pkg::*;

  logic [DATA_W-1:0] start_gain;
  stage_t            pipe [ITERATIONS+1];

  assign busy = 1'b0;

  csc_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start_gain (start_gain)
  );

  csc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .angle      (angle),
    .start_gain (start_gain),
    .stage_out  (pipe[0])
  );

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
    csc_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .idx       (SHIFT_W'(k)),
      .stage_in  (pipe[k]),
      .stage_out (pipe[k+1])
    );
  end

  assign done   = pipe[ITERATIONS].valid;
  assign sine   = pipe[ITERATIONS].s;
  assign cosine = pipe[ITERATIONS].c;

endmodule
`default_nettype wire
